@@ rtl/core/baca_pkg.sv @@
// ----------------------------------------------------------------------------
// baca_pkg
// Types and codes shared by the binary Aho-Corasick automaton block.
// ----------------------------------------------------------------------------
package baca_pkg;

    typedef struct packed {
        logic [1:0] cmd;
        logic       bit_value;
        logic       pattern_end;
        logic [7:0] current_node;
    } t_in_req;

    typedef struct packed {
        logic [7:0] node;
        logic       terminal;
        logic       overflow;
        logic [7:0] node_count;
    } t_out_req;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_BUILD  = 2'd2;
    localparam logic [1:0] CMD_STEP   = 2'd3;

    localparam int UOP_W = 5;

    localparam logic [UOP_W-1:0] U_NONE   = 5'd0;
    localparam logic [UOP_W-1:0] U_LOAD   = 5'd1;
    localparam logic [UOP_W-1:0] U_CLR0   = 5'd2;
    localparam logic [UOP_W-1:0] U_CLR1   = 5'd3;
    localparam logic [UOP_W-1:0] U_INS_RD = 5'd4;
    localparam logic [UOP_W-1:0] U_INS_EV = 5'd5;
    localparam logic [UOP_W-1:0] U_INS_A1 = 5'd6;
    localparam logic [UOP_W-1:0] U_INS_A2 = 5'd7;
    localparam logic [UOP_W-1:0] U_INS_TM = 5'd8;
    localparam logic [UOP_W-1:0] U_Q_RD   = 5'd9;
    localparam logic [UOP_W-1:0] U_Q_TM   = 5'd10;
    localparam logic [UOP_W-1:0] U_Q_FIN  = 5'd11;
    localparam logic [UOP_W-1:0] U_B_ER   = 5'd12;
    localparam logic [UOP_W-1:0] U_B_EW   = 5'd13;
    localparam logic [UOP_W-1:0] U_B_ET   = 5'd14;
    localparam logic [UOP_W-1:0] U_B_POP  = 5'd15;
    localparam logic [UOP_W-1:0] U_B_FL   = 5'd16;
    localparam logic [UOP_W-1:0] U_B_FF   = 5'd17;
    localparam logic [UOP_W-1:0] U_PUSH   = 5'd18;

    typedef struct packed {
        logic [UOP_W-1:0] uop;
    } t_ctl;

    typedef struct packed {
        logic ins_new;
        logic q_empty;
        logic bit_last;
        logic out_space;
    } t_sts;

endpackage

@@ rtl/core/baca_ctrl.sv @@
// ----------------------------------------------------------------------------
// baca_ctrl
// Sequencer: walks each command through its datapath micro-operations.
// ----------------------------------------------------------------------------
module baca_ctrl
    import baca_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_cmd,
    input  t_sts       i_sts,
    output t_ctl       o_ctl,
    output logic       o_in_ready
);

    localparam logic [4:0] S_BOOT0  = 5'd0;
    localparam logic [4:0] S_BOOT1  = 5'd1;
    localparam logic [4:0] S_IDLE   = 5'd2;
    localparam logic [4:0] S_CLR0   = 5'd3;
    localparam logic [4:0] S_CLR1   = 5'd4;
    localparam logic [4:0] S_INS_RD = 5'd5;
    localparam logic [4:0] S_INS_EV = 5'd6;
    localparam logic [4:0] S_INS_A1 = 5'd7;
    localparam logic [4:0] S_INS_A2 = 5'd8;
    localparam logic [4:0] S_INS_TM = 5'd9;
    localparam logic [4:0] S_Q_RD   = 5'd10;
    localparam logic [4:0] S_Q_TM   = 5'd11;
    localparam logic [4:0] S_Q_FIN  = 5'd12;
    localparam logic [4:0] S_B_ER   = 5'd13;
    localparam logic [4:0] S_B_EW   = 5'd14;
    localparam logic [4:0] S_B_ET   = 5'd15;
    localparam logic [4:0] S_B_POP  = 5'd16;
    localparam logic [4:0] S_B_FL   = 5'd17;
    localparam logic [4:0] S_B_FF   = 5'd18;
    localparam logic [4:0] S_PUSH   = 5'd19;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_comb begin
        n_state   = r_state;
        o_ctl.uop = U_NONE;
        case (r_state)
            S_BOOT0: begin
                o_ctl.uop = U_CLR0;
                n_state   = S_BOOT1;
            end
            S_BOOT1: begin
                o_ctl.uop = U_CLR1;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.uop = U_LOAD;
                    case (i_cmd)
                        CMD_CLEAR:  n_state = S_CLR0;
                        CMD_INSERT: n_state = S_INS_RD;
                        CMD_BUILD:  n_state = S_B_ER;
                        CMD_STEP:   n_state = S_Q_RD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR0: begin
                o_ctl.uop = U_CLR0;
                n_state   = S_CLR1;
            end
            S_CLR1: begin
                o_ctl.uop = U_CLR1;
                n_state   = S_PUSH;
            end
            S_INS_RD: begin
                o_ctl.uop = U_INS_RD;
                n_state   = S_INS_EV;
            end
            S_INS_EV: begin
                o_ctl.uop = U_INS_EV;
                n_state   = i_sts.ins_new ? S_INS_A1 : S_INS_TM;
            end
            S_INS_A1: begin
                o_ctl.uop = U_INS_A1;
                n_state   = S_INS_A2;
            end
            S_INS_A2: begin
                o_ctl.uop = U_INS_A2;
                n_state   = S_INS_TM;
            end
            S_INS_TM: begin
                o_ctl.uop = U_INS_TM;
                n_state   = S_PUSH;
            end
            S_Q_RD: begin
                o_ctl.uop = U_Q_RD;
                n_state   = S_Q_TM;
            end
            S_Q_TM: begin
                o_ctl.uop = U_Q_TM;
                n_state   = S_Q_FIN;
            end
            S_Q_FIN: begin
                o_ctl.uop = U_Q_FIN;
                n_state   = S_PUSH;
            end
            S_B_ER: begin
                o_ctl.uop = U_B_ER;
                n_state   = S_B_EW;
            end
            S_B_EW: begin
                o_ctl.uop = U_B_EW;
                n_state   = S_B_ET;
            end
            S_B_ET: begin
                o_ctl.uop = U_B_ET;
                n_state   = i_sts.bit_last ? S_B_POP : S_B_ER;
            end
            S_B_POP: begin
                o_ctl.uop = U_B_POP;
                n_state   = i_sts.q_empty ? S_PUSH : S_B_FL;
            end
            S_B_FL: begin
                o_ctl.uop = U_B_FL;
                n_state   = S_B_FF;
            end
            S_B_FF: begin
                o_ctl.uop = U_B_FF;
                n_state   = S_B_ER;
            end
            S_PUSH: begin
                o_ctl.uop = U_PUSH;
                if (i_sts.out_space) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_BOOT0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ rtl/core/baca_dp.sv @@
// ----------------------------------------------------------------------------
// baca_dp
// Datapath: edge, terminal, failure and queue memories, cursors and the
// result register.
// ----------------------------------------------------------------------------
module baca_dp
    import baca_pkg::*;
#(
    parameter int NODE_CAPACITY = 256
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_ctl     i_ctl,
    input  t_in_req  i_in_data,
    input  logic     i_out_ready,
    output t_sts     o_sts,
    output logic     o_out_valid,
    output t_out_req o_out_data
);

    localparam int NW = $clog2(NODE_CAPACITY);
    localparam int WX = (NW > 8) ? NW : 8;

    typedef struct packed {
        logic          is_trie;
        logic [NW-1:0] child;
    } t_edge;

    function automatic logic [7:0] f_to8(input logic [NW-1:0] v);
        logic [WX-1:0] x;
        x = WX'(v);
        return x[7:0];
    endfunction

    // memories
    t_edge         r_edge_mem [2*NODE_CAPACITY];
    logic          r_term_mem [NODE_CAPACITY];
    logic [NW-1:0] r_fail_mem [NODE_CAPACITY];
    logic [NW-1:0] r_q_mem    [NODE_CAPACITY];

    logic          e_we, e_re_a, e_re_b;
    logic [NW:0]   e_wa, e_ra_a, e_ra_b;
    t_edge         e_wd;
    logic          t_we, t_re, t_wd;
    logic [NW-1:0] t_wa, t_ra;
    logic          f_we, f_re;
    logic [NW-1:0] f_wa, f_ra, f_wd;
    logic          q_we, q_re;
    logic [NW-1:0] q_wa, q_ra, q_wd;

    t_edge         r_ed_a, r_ed_b;
    logic          r_term_rd;
    logic [NW-1:0] r_fail_rd, r_q_rd;

    // state
    t_in_req       r_req, n_req;
    logic [NW-1:0] r_highest, n_highest;
    logic [NW-1:0] r_cursor, n_cursor;
    logic [NW-1:0] r_parent, n_parent;
    logic [NW-1:0] r_u, n_u;
    logic          r_new, n_new;
    logic          r_ovf, n_ovf;
    logic          r_qv, n_qv;
    logic [NW-1:0] r_head, n_head;
    logic [NW-1:0] r_tail, n_tail;
    logic [NW-1:0] r_r, n_r;
    logic [NW-1:0] r_f, n_f;
    logic          r_b, n_b;
    logic          r_root, n_root;
    t_out_req      r_res, n_res;
    t_out_req      r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic          w_full;
    logic [NW-1:0] w_next_node;
    logic [NW-1:0] w_u;
    logic [WX-1:0] w_cur_x;
    logic          w_push;

    assign w_full      = (r_highest == NW'(NODE_CAPACITY - 1));
    assign w_next_node = r_highest + 1'b1;
    assign w_cur_x     = WX'(r_req.current_node);
    assign w_push      = (i_ctl.uop == U_PUSH) && (!r_out_valid || i_out_ready);

    assign o_sts.ins_new   = !r_ed_a.is_trie && !w_full;
    assign o_sts.q_empty   = (r_head == r_tail);
    assign o_sts.bit_last  = r_b;
    assign o_sts.out_space = !r_out_valid || i_out_ready;

    always_comb begin
        n_req = r_req;  n_highest = r_highest;  n_cursor = r_cursor;
        n_parent = r_parent;  n_u = r_u;  n_new = r_new;  n_ovf = r_ovf;
        n_qv = r_qv;  n_head = r_head;  n_tail = r_tail;  n_r = r_r;
        n_f = r_f;  n_b = r_b;  n_root = r_root;  n_res = r_res;
        w_u = r_cursor;
        e_we = 1'b0;  e_wa = '0;  e_wd = '0;
        e_re_a = 1'b0;  e_ra_a = '0;  e_re_b = 1'b0;  e_ra_b = '0;
        t_we = 1'b0;  t_wa = '0;  t_wd = 1'b0;  t_re = 1'b0;  t_ra = '0;
        f_we = 1'b0;  f_wa = '0;  f_wd = '0;  f_re = 1'b0;  f_ra = '0;
        q_we = 1'b0;  q_wa = '0;  q_wd = '0;  q_re = 1'b0;  q_ra = '0;
        case (i_ctl.uop)
            U_LOAD: begin
                n_req  = i_in_data;
                n_r    = '0;
                n_f    = '0;
                n_b    = 1'b0;
                n_root = 1'b1;
                n_head = '0;
                n_tail = '0;
            end
            U_CLR0: begin
                e_we      = 1'b1;
                e_wa      = {{NW{1'b0}}, 1'b0};
                t_we      = 1'b1;
                t_wa      = '0;
                n_highest = '0;
                n_cursor  = '0;
            end
            U_CLR1: begin
                e_we  = 1'b1;
                e_wa  = {{NW{1'b0}}, 1'b1};
                n_res = '{node: 8'd0, terminal: 1'b0, overflow: 1'b0,
                          node_count: f_to8(r_highest)};
            end
            U_INS_RD: begin
                e_re_a = 1'b1;
                e_ra_a = {r_cursor, r_req.bit_value};
            end
            U_INS_EV: begin
                n_parent = r_cursor;
                n_new    = 1'b0;
                n_ovf    = 1'b0;
                if (r_ed_a.is_trie) begin
                    w_u = r_ed_a.child;
                end else if (!w_full) begin
                    w_u       = w_next_node;
                    n_highest = w_next_node;
                    n_new     = 1'b1;
                    e_we      = 1'b1;
                    e_wa      = {w_next_node, 1'b0};
                end else begin
                    w_u   = r_cursor;
                    n_ovf = 1'b1;
                end
                n_u = w_u;
                if (n_new) begin
                    t_we = 1'b1;
                    t_wa = w_u;
                    t_wd = r_req.pattern_end;
                end else begin
                    t_re = 1'b1;
                    t_ra = w_u;
                    t_we = r_req.pattern_end;
                    t_wa = w_u;
                    t_wd = 1'b1;
                end
                n_cursor = r_req.pattern_end ? '0 : w_u;
            end
            U_INS_A1: begin
                e_we = 1'b1;
                e_wa = {r_u, 1'b1};
            end
            U_INS_A2: begin
                e_we = 1'b1;
                e_wa = {r_parent, r_req.bit_value};
                e_wd = '{is_trie: 1'b1, child: r_u};
            end
            U_INS_TM: begin
                n_res = '{node: f_to8(r_u),
                          terminal: r_req.pattern_end | (!r_new & r_term_rd),
                          overflow: r_ovf, node_count: f_to8(r_highest)};
            end
            U_Q_RD: begin
                n_qv   = (w_cur_x <= WX'(r_highest));
                e_re_a = 1'b1;
                e_ra_a = {w_cur_x[NW-1:0], r_req.bit_value};
            end
            U_Q_TM: begin
                t_re = 1'b1;
                t_ra = r_ed_a.child;
            end
            U_Q_FIN: begin
                if (r_qv) begin
                    n_res = '{node: f_to8(r_ed_a.child), terminal: r_term_rd,
                              overflow: 1'b0, node_count: f_to8(r_highest)};
                end else begin
                    n_res = '{node: 8'd0, terminal: 1'b0, overflow: 1'b0,
                              node_count: f_to8(r_highest)};
                end
            end
            U_B_ER: begin
                e_re_a = 1'b1;
                e_ra_a = {r_r, r_b};
                e_re_b = 1'b1;
                e_ra_b = {r_f, r_b};
            end
            U_B_EW: begin
                n_u = r_ed_a.child;
                if (r_ed_a.is_trie) begin
                    f_we   = 1'b1;
                    f_wa   = r_ed_a.child;
                    f_wd   = r_root ? '0 : r_ed_b.child;
                    q_we   = 1'b1;
                    q_wa   = r_tail;
                    q_wd   = r_ed_a.child;
                    n_tail = r_tail + 1'b1;
                    t_re   = !r_root;
                    t_ra   = r_ed_b.child;
                end else if (!r_root) begin
                    // missing edge takes the failure node's goto target
                    e_we = 1'b1;
                    e_wa = {r_r, r_b};
                    e_wd = '{is_trie: 1'b0, child: r_ed_b.child};
                end
            end
            U_B_ET: begin
                if (r_ed_a.is_trie && !r_root && r_term_rd) begin
                    t_we = 1'b1;
                    t_wa = r_u;
                    t_wd = 1'b1;
                end
                n_b = ~r_b;
            end
            U_B_POP: begin
                if (r_head != r_tail) begin
                    q_re   = 1'b1;
                    q_ra   = r_head;
                    n_head = r_head + 1'b1;
                end else begin
                    n_res = '{node: 8'd0, terminal: 1'b0, overflow: 1'b0,
                              node_count: f_to8(r_highest)};
                end
            end
            U_B_FL: begin
                n_r    = r_q_rd;
                f_re   = 1'b1;
                f_ra   = r_q_rd;
                n_root = 1'b0;
            end
            U_B_FF: begin
                n_f = r_fail_rd;
            end
            default: begin
            end
        endcase
        n_out       = w_push ? r_res : r_out;
        n_out_valid = w_push ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            r_edge_mem[e_wa] <= e_wd;
        end
        if (e_re_a) begin
            r_ed_a <= r_edge_mem[e_ra_a];
        end
        if (e_re_b) begin
            r_ed_b <= r_edge_mem[e_ra_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_term_mem[t_wa] <= t_wd;
        end
        if (t_re) begin
            r_term_rd <= r_term_mem[t_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            r_fail_mem[f_wa] <= f_wd;
        end
        if (f_re) begin
            r_fail_rd <= r_fail_mem[f_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_q_mem[q_wa] <= q_wd;
        end
        if (q_re) begin
            r_q_rd <= r_q_mem[q_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest   <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_highest   <= n_highest;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_parent <= n_parent;
        r_u      <= n_u;
        r_new    <= n_new;
        r_ovf    <= n_ovf;
        r_qv     <= n_qv;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_r      <= n_r;
        r_f      <= n_f;
        r_b      <= n_b;
        r_root   <= n_root;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/core/binary_aho_corasick_automaton_top.sv @@
// ----------------------------------------------------------------------------
// binary_aho_corasick_automaton_top
// Aho-Corasick automaton over a two-symbol alphabet: clear, insert pattern
// bits, build failure links, step queries.
//
//   channel | direction | handshake                | payload
//   request | in        | i_in_valid / o_in_ready  | i_in_data  (t_in_req)
//   result  | out       | o_out_valid / i_out_ready| o_out_data (t_out_req)
//
// One request at a time, one result per request. Each command runs through
// its sequencer states and ends in the push of its result: insert adds the
// A1 and A2 steps when a node is allocated, and build repeats the read, write
// and terminal steps for each edge of the root and of every node it dequeues.
// After reset the sequencer clears the root before it takes the first request.
// A waiting result stalls only the finish of the following request.
// ----------------------------------------------------------------------------
module binary_aho_corasick_automaton_top
    import baca_pkg::*;
#(
    parameter int NODE_CAPACITY = 256
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_data
);

    t_ctl w_ctl;
    t_sts w_sts;

    baca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_in_data.cmd),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl),
        .o_in_ready (o_in_ready)
    );

    baca_dp #(
        .NODE_CAPACITY (NODE_CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ rtl/core/baca_chk.sv @@
// ----------------------------------------------------------------------------
// baca_chk
// Port-level checks for the automaton top level, bound to every instance.
// ----------------------------------------------------------------------------
module baca_chk
    import baca_pkg::*;
#(
    parameter int NODE_CAPACITY = 256
)
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_out_req o_out_data
);

    localparam logic [7:0] TOP_NODE = 8'(NODE_CAPACITY - 1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while previous one in progress");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflow |-> o_out_data.node_count == TOP_NODE)
        else $error("overflow flagged with node store not full");

endmodule

bind binary_aho_corasick_automaton_top baca_chk #(
    .NODE_CAPACITY (NODE_CAPACITY)
) u_baca_chk (.*);
